// ===== rtl/first_fit_heap_allocator_defines.svh =====
// assertion macros shared by the first-fit heap allocator checker
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ffha_pkg.sv =====
// shared constants, codes and controller/datapath types of the heap allocator
package ffha_pkg;

  localparam int unsigned HEAP_WORDS  = 1024;
  localparam int unsigned ADDR_W      = $clog2(HEAP_WORDS);
  localparam int unsigned HDR_W       = 13;
  localparam int unsigned LEN_W       = 12;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned HDR_BYTES   = 4;
  localparam int unsigned ALIGN_BYTES = 8;
  // width of an unclamped next-block index
  localparam int unsigned NXT_W = ((ADDR_W > HDR_W - 2) ? ADDR_W : HDR_W - 2) + 1;
  // largest block that still leaves room for the sentinel
  localparam logic [31:0] FMT_CAP = 32'(((HEAP_WORDS - 1) / 2) * ALIGN_BYTES);
  localparam logic [LEN_W-1:0] HEAP_BYTES_RST = LEN_W'(4084);

  localparam logic [MODE_W-1:0] MODE_ALLOC    = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_FREE     = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_COALESCE = MODE_W'(2);

  localparam logic [STATUS_W-1:0] STATUS_OK      = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_NOFIT   = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_BADFREE = STATUS_W'(2);

  typedef logic [ADDR_W-1:0] widx_t;
  typedef logic [HDR_W-1:0]  hdr_t;

  typedef enum logic [3:0] {
    ST_FMT_HDR,
    ST_FMT_SENT,
    ST_IDLE,
    ST_AL_RD,
    ST_AL_EV,
    ST_AL_SPLIT,
    ST_FR_RD,
    ST_FR_EV,
    ST_CO_RDP,
    ST_CO_EVP,
    ST_CO_RDN,
    ST_CO_EVN,
    ST_DONE
  } ctl_state_e;

  typedef struct packed {
    logic fmt_hdr;
    logic fmt_sent;
    logic start;
    logic rd_p;
    logic rd_n;
    logic al_commit;
    logic al_split;
    logic fr_commit;
    logic step_p;
    logic co_load;
    logic co_merge;
    logic co_adv;
    logic set_nofit;
    logic set_badfree;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic p_end;
    logic n_end;
    logic fit;
    logic split;
    logic match;
    logic alloc_bit;
    logic both_free;
  } dp_sts_t;

endpackage

// ===== rtl/ffha_if.sv =====
// valid/ready channel interfaces for request and response beats
interface ffha_in_if import ffha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [LEN_W-1:0]  length;
  logic [LEN_W-1:0]  address;

  modport source (output valid, output mode, output length, output address, input ready);
  modport sink   (input valid, input mode, input length, input address, output ready);
endinterface

interface ffha_out_if import ffha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LEN_W-1:0]    address_res;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output address_res, output status, input ready);
  modport sink   (input valid, input address_res, input status, output ready);
endinterface

// ===== rtl/ffha_ram.sv =====
// generic single-write single-read ram with registered read data
module ffha_ram #(
  parameter int unsigned Width = 13,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ffha_ctrl.sv =====
// controller state machine of the heap allocator
module ffha_ctrl import ffha_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              in_valid_i,
  input  logic [MODE_W-1:0] in_mode_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dp_sts_t           sts_i,
  output ctl_cmd_t          cmd_o
);

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FMT_HDR:  state_d = ST_FMT_SENT;
      ST_FMT_SENT: state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_mode_i)
            MODE_ALLOC:    state_d = ST_AL_RD;
            MODE_FREE:     state_d = ST_FR_RD;
            MODE_COALESCE: state_d = ST_CO_RDP;
            default:       state_d = ST_DONE;
          endcase
        end
      end
      ST_AL_RD:    state_d = sts_i.p_end ? ST_DONE : ST_AL_EV;
      ST_AL_EV: begin
        if (sts_i.fit) begin
          state_d = sts_i.split ? ST_AL_SPLIT : ST_DONE;
        end else begin
          state_d = ST_AL_RD;
        end
      end
      ST_AL_SPLIT: state_d = ST_DONE;
      ST_FR_RD:    state_d = sts_i.p_end ? ST_DONE : ST_FR_EV;
      ST_FR_EV:    state_d = sts_i.match ? ST_DONE : ST_FR_RD;
      ST_CO_RDP:   state_d = ST_CO_EVP;
      ST_CO_EVP:   state_d = ST_CO_RDN;
      ST_CO_RDN:   state_d = sts_i.n_end ? ST_DONE : ST_CO_EVN;
      ST_CO_EVN:   state_d = ST_CO_RDN;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_FMT_HDR;
    endcase
    // a new heap size reformats the store
    if (cfg_we_i) begin
      state_d = ST_FMT_HDR;
    end
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_FMT_HDR:  cmd_o.fmt_hdr = 1'b1;
      ST_FMT_SENT: cmd_o.fmt_sent = 1'b1;
      ST_IDLE: begin
        in_ready_o  = !cfg_we_i;
        cmd_o.start = !cfg_we_i && in_valid_i;
      end
      ST_AL_RD: begin
        cmd_o.set_nofit = sts_i.p_end;
        cmd_o.rd_p      = !sts_i.p_end;
      end
      ST_AL_EV: begin
        cmd_o.al_commit = sts_i.fit;
        cmd_o.step_p    = !sts_i.fit;
      end
      ST_AL_SPLIT: cmd_o.al_split = 1'b1;
      ST_FR_RD: begin
        cmd_o.set_badfree = sts_i.p_end;
        cmd_o.rd_p        = !sts_i.p_end;
      end
      ST_FR_EV: begin
        cmd_o.fr_commit   = sts_i.match && sts_i.alloc_bit;
        cmd_o.set_badfree = sts_i.match && !sts_i.alloc_bit;
        cmd_o.step_p      = !sts_i.match;
      end
      ST_CO_RDP:   cmd_o.rd_p = 1'b1;
      ST_CO_EVP:   cmd_o.co_load = 1'b1;
      ST_CO_RDN:   cmd_o.rd_n = !sts_i.n_end;
      ST_CO_EVN: begin
        cmd_o.co_merge = sts_i.both_free;
        cmd_o.co_adv   = !sts_i.both_free;
      end
      ST_DONE:     cmd_o.out_load = !out_valid_q || out_ready_i;
      default:     cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FMT_HDR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/ffha_dpath.sv =====
// datapath of the heap allocator: header store, block walk registers, result
module ffha_dpath import ffha_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LEN_W-1:0]    cfg_wdata_i,
  input  logic [LEN_W-1:0]    in_length_i,
  input  logic [LEN_W-1:0]    in_address_i,
  input  ctl_cmd_t            cmd_i,
  output dp_sts_t             sts_o,
  output logic [LEN_W-1:0]    out_address_res_o,
  output logic [STATUS_W-1:0] out_status_o
);

  // index of the block after p, clamped to the sentinel
  function automatic widx_t blk_next(widx_t p, hdr_t h, widx_t sent);
    logic [NXT_W-1:0] n;
    n = NXT_W'(p) + NXT_W'(h[HDR_W-1:2]) + NXT_W'(1);
    if (n > NXT_W'(sent)) begin
      return sent;
    end
    return n[ADDR_W-1:0];
  endfunction

  // payload byte offset of the block whose header sits at word p
  function automatic logic [LEN_W-1:0] payload_off(widx_t p);
    logic [ADDR_W+2:0] off;
    off = {(ADDR_W+1)'(p) + (ADDR_W+1)'(1), 2'b00};
    return LEN_W'(off);
  endfunction

  logic [LEN_W-1:0]    heap_bytes_q;
  widx_t               sent_q;
  widx_t               p_q, n_q;
  hdr_t                hp_q, need_q;
  logic [LEN_W-1:0]    addr_q;
  logic [LEN_W-1:0]    res_addr_q, out_addr_q;
  logic [STATUS_W-1:0] res_status_q, out_status_q;

  hdr_t  rd_data;
  hdr_t  need_sum, need_in;
  hdr_t  fmt_sum, fmt_raw, fmt_mem;
  widx_t fmt_sent_idx;
  hdr_t  merged;
  widx_t split_idx;
  logic  ram_we, ram_re;
  widx_t ram_waddr, ram_raddr;
  hdr_t  ram_wdata;

  // payload size: length plus header rounded up to the alignment, minus header
  assign need_sum = HDR_W'(in_length_i) + HDR_W'(HDR_BYTES + ALIGN_BYTES - 1);
  assign need_in  = {need_sum[HDR_W-1:3], 3'b000} - HDR_W'(HDR_BYTES);

  // one free block spanning the heap, capped to leave the sentinel in range
  assign fmt_sum      = HDR_W'(heap_bytes_q) + HDR_W'(HDR_BYTES + ALIGN_BYTES - 1);
  assign fmt_raw      = {fmt_sum[HDR_W-1:3], 3'b000};
  assign fmt_mem      = (32'(fmt_raw) > FMT_CAP) ? HDR_W'(FMT_CAP) : fmt_raw;
  assign fmt_sent_idx = ADDR_W'(fmt_mem >> 2);

  assign merged    = hp_q + rd_data + HDR_W'(HDR_BYTES);
  assign split_idx = blk_next(p_q, need_q, sent_q);

  always_comb begin
    ram_waddr = p_q;
    ram_wdata = rd_data;
    if (cmd_i.fmt_hdr) begin
      ram_waddr = '0;
      ram_wdata = fmt_mem - HDR_W'(HDR_BYTES);
    end else if (cmd_i.fmt_sent) begin
      ram_waddr = sent_q;
      ram_wdata = '0;
    end else if (cmd_i.al_commit) begin
      ram_wdata = need_q | HDR_W'(1);
    end else if (cmd_i.al_split) begin
      ram_waddr = split_idx;
      ram_wdata = rd_data - need_q - HDR_W'(HDR_BYTES);
    end else if (cmd_i.fr_commit) begin
      ram_wdata = {rd_data[HDR_W-1:1], 1'b0};
    end else if (cmd_i.co_merge) begin
      ram_wdata = merged;
    end
  end

  assign ram_we = cmd_i.fmt_hdr | cmd_i.fmt_sent | cmd_i.al_commit | cmd_i.al_split
                | cmd_i.fr_commit | cmd_i.co_merge;
  assign ram_re    = cmd_i.rd_p | cmd_i.rd_n;
  assign ram_raddr = cmd_i.rd_n ? n_q : p_q;

  ffha_ram #(
    .Width (HDR_W),
    .Depth (HEAP_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  always_comb begin
    sts_o.p_end     = p_q >= sent_q;
    sts_o.n_end     = n_q >= sent_q;
    sts_o.fit       = (rd_data >= need_q) && !rd_data[0];
    sts_o.split     = {1'b0, rd_data} >= ({1'b0, need_q} + (HDR_W+1)'(ALIGN_BYTES));
    sts_o.match     = payload_off(p_q) == addr_q;
    sts_o.alloc_bit = rd_data[0];
    sts_o.both_free = !hp_q[0] && !rd_data[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_bytes_q <= HEAP_BYTES_RST;
      sent_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        heap_bytes_q <= cfg_wdata_i;
      end
      if (cmd_i.fmt_hdr) begin
        sent_q <= fmt_sent_idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      p_q          <= '0;
      need_q       <= need_in;
      addr_q       <= in_address_i;
      res_addr_q   <= '0;
      res_status_q <= STATUS_OK;
    end
    if (cmd_i.step_p) begin
      p_q <= blk_next(p_q, rd_data, sent_q);
    end
    if (cmd_i.al_commit) begin
      res_addr_q <= payload_off(p_q);
    end
    if (cmd_i.set_nofit) begin
      res_status_q <= STATUS_NOFIT;
    end
    if (cmd_i.set_badfree) begin
      res_status_q <= STATUS_BADFREE;
    end
    if (cmd_i.co_load) begin
      hp_q <= rd_data;
      n_q  <= blk_next(p_q, rd_data, sent_q);
    end
    if (cmd_i.co_merge) begin
      hp_q <= merged;
      n_q  <= blk_next(p_q, merged, sent_q);
    end
    if (cmd_i.co_adv) begin
      p_q  <= n_q;
      hp_q <= rd_data;
      n_q  <= blk_next(n_q, rd_data, sent_q);
    end
    if (cmd_i.out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_address_res_o = out_addr_q;
  assign out_status_o      = out_status_q;

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// top level of the first-fit heap allocator
//
// request channel in_i: mode (allocate, free, coalesce), length, address.
// response channel out_o: address_res and status, one beat per request beat,
// in request order. cfg_we_i/cfg_wdata_i set the usable heap size and
// reformat the heap as one free block; write only while the block is idle.
//
// the header store has one read port with registered data, so each block
// visited takes a read step and an evaluate step. allocate and free walk the
// blocks from the first until a fitting block (allocate, plus a split step
// for a split) or the addressed block (free) is found or the sentinel is
// reached; coalesce reads the first header, then each next header up to the
// sentinel; unused mode 3 goes straight to the response. the next request is
// taken at the earliest as the response is first offered, so requests are
// handled one at a time; the walk time is set by the number of blocks.
//
// reset and every heap size write run a format (first header, then
// sentinel) with in_i.ready low. results sit in an output register, so one
// new request is taken while a response waits on a stalled receiver; a
// second finished result then holds until the register drains.
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  ffha_in_if.sink          in_i,
  ffha_out_if.source       out_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencing: format, block walks, response handoff
  ffha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (in_i.valid),
    .in_mode_i   (in_i.mode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // header store, walk pointers and the response register
  ffha_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_length_i       (in_i.length),
    .in_address_i      (in_i.address),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_address_res_o (out_o.address_res),
    .out_status_o      (out_o.status)
  );

endmodule

// ===== rtl/ffha_checker.sv =====
// port-level checks of the heap allocator, bound to the top level
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker import ffha_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [LEN_W-1:0]    out_address_res_i,
  input logic [STATUS_W-1:0] out_status_i
);

  // a stalled response beat stays offered
  `FFHA_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "response dropped")

  // a failed request returns no offset
  `FFHA_ASSERT_NOW(a_fail_zero, out_valid_i && (out_status_i != STATUS_OK),
                   out_address_res_i == '0, "offset on failed request")

  // payload offsets are word aligned
  `FFHA_ASSERT_NOW(a_off_align, out_valid_i, out_address_res_i[1:0] == 2'b00,
                   "unaligned offset")

  // a heap size write blocks requests while the heap is formatted
  `FFHA_ASSERT_NEXT(a_fmt_block, cfg_we_i, !in_ready_i, "request taken during format")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .cfg_we_i          (cfg_we_i),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_address_res_i (out_o.address_res),
  .out_status_i      (out_o.status)
);
